// ===== rtl/ttd_pkg.sv =====
// shared constants and types for the tiled texel decoder
package ttd_pkg;

    localparam int IDX_W      = 20;
    localparam int RAW_W      = 16;
    localparam int OFS_W      = 20;
    localparam int PIX_W      = 32;
    localparam int O_W        = IDX_W + 1;
    localparam int DIM_W      = 11;
    localparam int LOG_W      = 2;
    localparam int FMT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int SAT_W      = 12;
    localparam int DIV_BPS    = 3;
    localparam int DIV_ST     = O_W / DIV_BPS;
    localparam int PROD_W     = O_W + 1;
    localparam int SUM_W      = 24;

    localparam logic [OFS_W-1:0] OFS_MAX = 20'hFFFFF;

    localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB5A3 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_I4     = 2'd2;
    localparam logic [FMT_W-1:0] FMT_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_H  = 3'd4;

    localparam logic [DIM_W-1:0] DIM_RESET  = 11'd8;
    localparam logic [LOG_W-1:0] LOG_RESET  = 2'd2;

    // per-result payload that rides beside the divider stages
    typedef struct packed {
        logic [2:0]       low;
        logic [2:0]       mid;
        logic [PIX_W-1:0] pix;
        logic             last;
    } t_pay;

endpackage

// ===== rtl/ttd_div_pipe.sv =====
// pipelined restoring divider, a few quotient bits per stage
module ttd_div_pipe #(
    parameter int VW = 11
) (
    input  logic                        i_clk,
    input  logic [ttd_pkg::DIV_ST-1:0]  i_en,
    input  logic [ttd_pkg::O_W-1:0]     i_dividend,
    input  logic [VW-1:0]               i_divisor,
    output logic [ttd_pkg::O_W-1:0]     o_quot,
    output logic [VW-1:0]               o_rem
);
    import ttd_pkg::*;

    logic [VW-1:0]  r_rem [DIV_ST];
    logic [O_W-1:0] r_acc [DIV_ST];
    logic [VW-1:0]  n_rem [DIV_ST];
    logic [O_W-1:0] n_acc [DIV_ST];

    always_comb begin
        logic [VW:0]    t;
        logic [VW-1:0]  rem;
        logic [O_W-1:0] acc;
        for (int k = 0; k < DIV_ST; k++) begin
            if (k == 0) begin
                rem = '0;
                acc = i_dividend;
            end else begin
                rem = r_rem[k-1];
                acc = r_acc[k-1];
            end
            // acc shifts dividend bits out at the top and quotient bits in at the bottom
            for (int j = 0; j < DIV_BPS; j++) begin
                t   = {rem, acc[O_W-1]};
                acc = {acc[O_W-2:0], 1'b0};
                if (t >= {1'b0, i_divisor}) begin
                    t      = t - {1'b0, i_divisor};
                    acc[0] = 1'b1;
                end
                rem = t[VW-1:0];
            end
            n_rem[k] = rem;
            n_acc[k] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_ST; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_acc[k] <= n_acc[k];
            end
        end
    end

    assign o_quot = r_acc[DIV_ST-1];
    assign o_rem  = r_rem[DIV_ST-1];

endmodule

// ===== rtl/tiled_texel_decoder_top.sv =====
// tiled texel decoder: byte swap, colour expansion and tile-to-linear offset
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_texel_index, i_raw_word
//  out     | output    | o_out_valid / i_out_stall | o_pixel_offset, o_pixel_value,
//          |           |                        | o_offset_clamped, o_last
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// from accept to the result on the output register an item passes the split stage, which
// loads at the accept edge, then seven divider stages, two offset stages and the output register
// one result leaves the split stage per cycle while stage 0 can load, so rgb565 and rgb5a3 take
// an item every cycle then, and i4 gives two results per item and takes the next with the second
// reset clears all valid bits and loads the register reset values
// a stalled output only holds the stages behind it that are full; bubbles close up
module tiled_texel_decoder_top #(
    parameter int MAX_DIM = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ttd_pkg::IDX_W-1:0]     i_texel_index,
    input  logic [ttd_pkg::RAW_W-1:0]     i_raw_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ttd_pkg::OFS_W-1:0]     o_pixel_offset,
    output logic [ttd_pkg::PIX_W-1:0]     o_pixel_value,
    output logic                          o_offset_clamped,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ttd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ttd_pkg::*;

    localparam int WW = $clog2(MAX_DIM + 1);
    localparam int AW = 2 * WW;
    localparam int NS = DIV_ST + 3;
    localparam int P1 = DIV_ST;
    localparam int P2 = DIV_ST + 1;
    localparam int PO = DIV_ST + 2;
    localparam logic [SAT_W-1:0] DIM_LIM = SAT_W'(MAX_DIM);

    // configuration
    logic [FMT_W-1:0] r_fmt;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [LOG_W-1:0] r_twl;
    logic [LOG_W-1:0] r_thl;
    logic [AW-1:0]    r_area;

    logic [SAT_W-1:0] w_ext;
    logic [SAT_W-1:0] h_ext;
    logic [WW-1:0]    w_sat;
    logic [WW-1:0]    h_sat;
    logic [WW-1:0]    tiles_across;
    logic             ta_zero;
    logic [2:0]       log_sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_RGB565;
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
            r_twl    <= LOG_RESET;
            r_thl    <= LOG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FORMAT: r_fmt    <= i_cfg_data[FMT_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_TILE_W: r_twl    <= i_cfg_data[LOG_W-1:0];
                CFG_TILE_H: r_thl    <= i_cfg_data[LOG_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_ext        = SAT_W'(r_width);
    assign h_ext        = SAT_W'(r_height);
    assign w_sat        = (w_ext > DIM_LIM) ? WW'(DIM_LIM) : WW'(w_ext);
    assign h_sat        = (h_ext > DIM_LIM) ? WW'(DIM_LIM) : WW'(h_ext);
    assign tiles_across = w_sat >> r_twl;
    assign ta_zero      = (tiles_across == '0);
    assign log_sum      = 3'(r_twl) + 3'(r_thl);

    // image area is registered and follows the registers in the cycle after they change
    always_ff @(posedge i_clk) begin
        r_area <= AW'(w_sat) * AW'(h_sat);
    end

    // split stage: one result per cycle while stage 0 can load, two results for an i4 byte
    logic              r_in_valid;
    logic              r_half;
    logic [IDX_W-1:0]  r_idx;
    logic [RAW_W-1:0]  r_raw;
    logic              piece_final;
    logic              in_accept;
    logic [NS-1:0]     ld;
    logic [NS-1:0]     r_v;

    logic [RAW_W-1:0]  sw;
    logic [3:0]        nib;
    logic [7:0]        ch_r;
    logic [7:0]        ch_g;
    logic [7:0]        ch_b;
    logic [7:0]        ch_a;
    logic [O_W-1:0]    pos;
    t_pay              piece;
    logic [O_W-1:0]    div_a;
    logic [O_W-1:0]    div_b;

    assign piece_final = (r_fmt != FMT_I4) || r_half;
    assign o_in_stall  = r_in_valid && !(ld[0] && piece_final);
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_half     <= 1'b0;
        end else if (in_accept) begin
            // the unused format code takes the transaction and makes nothing
            r_in_valid <= (r_fmt != FMT_NONE);
            r_half     <= 1'b0;
        end else if (r_in_valid && ld[0]) begin
            if (piece_final) begin
                r_in_valid <= 1'b0;
            end else begin
                r_half <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_idx <= i_texel_index;
            r_raw <= i_raw_word;
        end
    end

    always_comb begin
        sw   = {r_raw[7:0], r_raw[15:8]};
        nib  = r_half ? r_raw[3:0] : r_raw[7:4];
        ch_a = 8'hFF;
        ch_r = '0;
        ch_g = '0;
        ch_b = '0;
        pos  = {1'b0, r_idx};
        case (r_fmt)
            FMT_RGB565: begin
                ch_r = {sw[15:11], 3'b000};
                ch_g = {sw[10:5], 2'b00};
                ch_b = {sw[4:0], 3'b000};
            end
            FMT_RGB5A3: begin
                if (sw[15]) begin
                    ch_r = {sw[14:10], 3'b000};
                    ch_g = {sw[9:5], 3'b000};
                    ch_b = {sw[4:0], 3'b000};
                end else begin
                    ch_r = {sw[11:8], 4'b0000};
                    ch_g = {sw[7:4], 4'b0000};
                    ch_b = {sw[3:0], 4'b0000};
                    ch_a = {sw[14:12], 5'b00000};
                end
            end
            FMT_I4: begin
                ch_r = {nib, 4'b0000};
                ch_g = {nib, 4'b0000};
                ch_b = {nib, 4'b0000};
                pos  = {r_idx, r_half};
            end
            default: ;
        endcase
        piece.pix  = {ch_a, ch_b, ch_g, ch_r};
        piece.last = piece_final;
        piece.low  = pos[2:0] & ~(3'b111 << r_twl);
        piece.mid  = 3'((pos[5:0] & ~(6'h3F << log_sum)) >> r_twl);
        div_a      = pos >> r_thl;
        div_b      = pos >> log_sum;
    end

    // flow control: a stage loads when empty or when the stage ahead loads
    always_comb begin
        ld[NS-1] = !r_v[NS-1] || !i_out_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= r_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // dividers: row of tiles from pos / (ty*w), tile column from tile number mod tiles across
    logic [O_W-1:0] quot_a;
    logic [WW-1:0]  rem_a_unused;
    logic [O_W-1:0] quot_b_unused;
    logic [WW-1:0]  rem_b;

    ttd_div_pipe #(.VW(WW)) u_div_row (
        .i_clk      (i_clk),
        .i_en       (ld[DIV_ST-1:0]),
        .i_dividend (div_a),
        .i_divisor  (w_sat),
        .o_quot     (quot_a),
        .o_rem      (rem_a_unused)
    );

    ttd_div_pipe #(.VW(WW)) u_div_col (
        .i_clk      (i_clk),
        .i_en       (ld[DIV_ST-1:0]),
        .i_dividend (div_b),
        .i_divisor  (tiles_across),
        .o_quot     (quot_b_unused),
        .o_rem      (rem_b)
    );

    t_pay r_pay [DIV_ST];

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_pay[0] <= piece;
        end
        for (int k = 1; k < DIV_ST; k++) begin
            if (ld[k]) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    // first offset stage: products and tile column term
    logic [O_W+WW-1:0] prod_full;
    logic [PROD_W-1:0] r_p1_prod;
    logic [WW+2:0]     r_p1_midt;
    logic [WW+2:0]     r_p1_col;
    logic [2:0]        r_p1_low;
    logic [PIX_W-1:0]  r_p1_pix;
    logic              r_p1_last;

    // a zero divisor gives a quotient of all ones, but the product is then zero anyway
    assign prod_full = quot_a * (O_W+WW)'(w_sat);

    always_ff @(posedge i_clk) begin
        if (ld[P1]) begin
            r_p1_prod <= prod_full[PROD_W-1:0];
            r_p1_midt <= (WW+3)'(r_pay[DIV_ST-1].mid) * (WW+3)'(w_sat);
            r_p1_col  <= ta_zero ? '0 : ((WW+3)'(rem_b) << r_twl);
            r_p1_low  <= r_pay[DIV_ST-1].low;
            r_p1_pix  <= r_pay[DIV_ST-1].pix;
            r_p1_last <= r_pay[DIV_ST-1].last;
        end
    end

    // second offset stage: the sum
    logic [SUM_W-1:0] r_p2_sum;
    logic [PIX_W-1:0] r_p2_pix;
    logic             r_p2_last;

    always_ff @(posedge i_clk) begin
        if (ld[P2]) begin
            r_p2_sum  <= SUM_W'(r_p1_low) + SUM_W'(r_p1_midt)
                       + (SUM_W'(r_p1_prod) << r_thl) + SUM_W'(r_p1_col);
            r_p2_pix  <= r_p1_pix;
            r_p2_last <= r_p1_last;
        end
    end

    // output register with the range check
    logic             clamp;
    logic [OFS_W-1:0] r_o_ofs;
    logic [PIX_W-1:0] r_o_pix;
    logic             r_o_clamp;
    logic             r_o_last;

    assign clamp = (r_p2_sum >= SUM_W'(r_area)) || (r_p2_sum > SUM_W'(OFS_MAX));

    always_ff @(posedge i_clk) begin
        if (ld[PO]) begin
            r_o_ofs   <= clamp ? '0 : r_p2_sum[OFS_W-1:0];
            r_o_pix   <= r_p2_pix;
            r_o_clamp <= clamp;
            r_o_last  <= r_p2_last;
        end
    end

    assign o_out_valid      = r_v[PO];
    assign o_pixel_offset   = r_o_ofs;
    assign o_pixel_value    = r_o_pix;
    assign o_offset_clamped = r_o_clamp;
    assign o_last           = r_o_last;

endmodule
